// ===== rtl/v4n_pkg.sv =====
// Shared types and constants for the vec4_normalize block.
// No dependencies.
package v4n_pkg;

  localparam int unsigned CompW  = 16;  // component width, signed Q4.12
  localparam int unsigned LenW   = 17;  // length width, unsigned Q5.12
  localparam int unsigned SqW    = 32;  // one square
  localparam int unsigned SumW   = 34;  // sum of four squares, padded to even
  localparam int unsigned RemW   = 20;  // root remainder
  localparam int unsigned QW     = 13;  // quotient bits, at most 4096
  localparam int unsigned NumW   = 30;  // dividend (mag << 12) + len/2
  localparam int unsigned FracW  = 12;  // fraction bits of Q4.12
  localparam logic [LenW-1:0] MinLenReset = 17'd1;

  typedef logic signed [CompW-1:0] comp_t;

endpackage

// ===== rtl/vec4_normalize.sv =====
// vec4_normalize: four-component vector normalization in Q4.12.
// One item accepted every cycle.
// The length comes from a 17-stage bit-per-stage square root; the division
// is a 13-stage restoring divider, one quotient bit per stage, per lane.
// busy is never raised; the receiver cannot stall. Reset clears all valid
// bits and sets min_length to 1.
module vec4_normalize
  import v4n_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [CompW-1:0] comp_x_i,
  input  logic signed [CompW-1:0] comp_y_i,
  input  logic signed [CompW-1:0] comp_z_i,
  input  logic signed [CompW-1:0] comp_w_i,
  output logic                    done_o,
  output logic signed [CompW-1:0] out_x_o,
  output logic signed [CompW-1:0] out_y_o,
  output logic signed [CompW-1:0] out_z_o,
  output logic signed [CompW-1:0] out_w_o,
  output logic [LenW-1:0]         vec_length_o,
  output logic                    was_normalized_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned RootSt = LenW;
  localparam int unsigned DivSt  = QW;

  // Configuration register
  logic [LenW-1:0] min_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MinLenReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      min_len_q <= pwdata[LenW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {{(32-LenW){1'b0}}, min_len_q};
  assign busy   = 1'b0;

  // Stage A: squares
  logic          a_vld_q;
  comp_t         a_c_q [4];
  logic [SqW-1:0] a_sq_q [4];
  comp_t         in_c [4];

  assign in_c[0] = comp_x_i;
  assign in_c[1] = comp_y_i;
  assign in_c[2] = comp_z_i;
  assign in_c[3] = comp_w_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else         a_vld_q <= start;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      a_c_q[i]  <= in_c[i];
      a_sq_q[i] <= SqW'(32'(in_c[i]) * 32'(in_c[i]));
    end
  end

  // Stage B: sum of squares
  logic            b_vld_q;
  comp_t           b_c_q [4];
  logic [SumW-1:0] b_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else         b_vld_q <= a_vld_q;
  end

  always_ff @(posedge clk_i) begin
    b_c_q   <= a_c_q;
    b_sum_q <= SumW'(a_sq_q[0]) + SumW'(a_sq_q[1]) + SumW'(a_sq_q[2]) + SumW'(a_sq_q[3]);
  end

  // Square root: one root bit per stage, radicand shifted out two bits a stage
  logic            r_vld_q  [RootSt+1];
  comp_t           r_c_q    [RootSt+1][4];
  logic [SumW-1:0] r_rad_q  [RootSt+1];
  logic [RemW-1:0] r_rem_q  [RootSt+1];
  logic [LenW-1:0] r_root_q [RootSt+1];

  assign r_vld_q[0]  = b_vld_q;
  assign r_c_q[0]    = b_c_q;
  assign r_rad_q[0]  = b_sum_q;
  assign r_rem_q[0]  = '0;
  assign r_root_q[0] = '0;

  for (genvar k = 0; k < RootSt; k++) begin : g_root
    logic [RemW-1:0] rem_in, trial;
    assign rem_in = {r_rem_q[k][RemW-3:0], r_rad_q[k][SumW-1:SumW-2]};
    assign trial  = {1'b0, r_root_q[k], 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) r_vld_q[k+1] <= 1'b0;
      else         r_vld_q[k+1] <= r_vld_q[k];
    end

    always_ff @(posedge clk_i) begin
      r_c_q[k+1]   <= r_c_q[k];
      r_rad_q[k+1] <= r_rad_q[k] << 2;
      if (rem_in >= trial) begin
        r_rem_q[k+1]  <= rem_in - trial;
        r_root_q[k+1] <= {r_root_q[k][LenW-2:0], 1'b1};
      end else begin
        r_rem_q[k+1]  <= rem_in;
        r_root_q[k+1] <= {r_root_q[k][LenW-2:0], 1'b0};
      end
    end
  end

  // Stage C: threshold compare and dividend setup
  logic            c_vld_q;
  logic            c_norm_q;
  comp_t           c_c_q [4];
  logic [LenW-1:0] c_len_q;
  logic [NumW-1:0] c_num_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_vld_q <= 1'b0;
    else         c_vld_q <= r_vld_q[RootSt];
  end

  always_ff @(posedge clk_i) begin
    c_c_q    <= r_c_q[RootSt];
    c_len_q  <= r_root_q[RootSt];
    c_norm_q <= r_root_q[RootSt] > min_len_q;
    for (int i = 0; i < 4; i++) begin
      logic [LenW-1:0] mag;
      mag = r_c_q[RootSt][i][CompW-1] ? LenW'(-LenW'($signed(r_c_q[RootSt][i])))
                                      : LenW'(r_c_q[RootSt][i]);
      c_num_q[i] <= {1'b0, mag, {FracW{1'b0}}} + NumW'(r_root_q[RootSt] >> 1);
    end
  end

  // Division: restoring, one quotient bit per stage, four lanes
  logic            d_vld_q  [DivSt+1];
  logic            d_norm_q [DivSt+1];
  comp_t           d_c_q    [DivSt+1][4];
  logic [LenW-1:0] d_len_q  [DivSt+1];
  logic [NumW-1:0] d_rem_q  [DivSt+1][4];
  logic [QW-1:0]   d_quo_q  [DivSt+1][4];

  assign d_vld_q[0]  = c_vld_q;
  assign d_norm_q[0] = c_norm_q;
  assign d_c_q[0]    = c_c_q;
  assign d_len_q[0]  = c_len_q;
  assign d_rem_q[0]  = c_num_q;
  for (genvar i = 0; i < 4; i++) begin : g_q0
    assign d_quo_q[0][i] = '0;
  end

  for (genvar j = 0; j < DivSt; j++) begin : g_div
    logic [NumW-1:0] dsh;
    assign dsh = NumW'(d_len_q[j]) << (DivSt - 1 - j);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) d_vld_q[j+1] <= 1'b0;
      else         d_vld_q[j+1] <= d_vld_q[j];
    end

    always_ff @(posedge clk_i) begin
      d_norm_q[j+1] <= d_norm_q[j];
      d_c_q[j+1]    <= d_c_q[j];
      d_len_q[j+1]  <= d_len_q[j];
      for (int i = 0; i < 4; i++) begin
        if (d_rem_q[j][i] >= dsh) begin
          d_rem_q[j+1][i] <= d_rem_q[j][i] - dsh;
          d_quo_q[j+1][i] <= {d_quo_q[j][i][QW-2:0], 1'b1};
        end else begin
          d_rem_q[j+1][i] <= d_rem_q[j][i];
          d_quo_q[j+1][i] <= {d_quo_q[j][i][QW-2:0], 1'b0};
        end
      end
    end
  end

  // Output stage: restore sign or pass through
  logic            o_vld_q;
  logic            o_norm_q;
  comp_t           o_c_q [4];
  logic [LenW-1:0] o_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_vld_q <= 1'b0;
    else         o_vld_q <= d_vld_q[DivSt];
  end

  always_ff @(posedge clk_i) begin
    o_norm_q <= d_norm_q[DivSt];
    o_len_q  <= d_len_q[DivSt];
    for (int i = 0; i < 4; i++) begin
      comp_t q;
      q = comp_t'(d_quo_q[DivSt][i]);
      if (!d_norm_q[DivSt])             o_c_q[i] <= d_c_q[DivSt][i];
      else if (d_c_q[DivSt][i][CompW-1]) o_c_q[i] <= -q;
      else                              o_c_q[i] <= q;
    end
  end

  assign done_o           = o_vld_q;
  assign out_x_o          = o_c_q[0];
  assign out_y_o          = o_c_q[1];
  assign out_z_o          = o_c_q[2];
  assign out_w_o          = o_c_q[3];
  assign vec_length_o     = o_len_q;
  assign was_normalized_o = o_norm_q;

endmodule

// ===== tb/vec4_normalize_checker.sv =====
// Checker for vec4_normalize: watches accepted items, config writes and results,
// predicts each result and compares it field by field. Depends on v4n_pkg.
`timescale 1ns / 100ps
module vec4_normalize_checker
  import v4n_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            busy,
  input  comp_t           comp_x_i,
  input  comp_t           comp_y_i,
  input  comp_t           comp_z_i,
  input  comp_t           comp_w_i,
  input  logic            done_o,
  input  comp_t           out_x_o,
  input  comp_t           out_y_o,
  input  comp_t           out_z_o,
  input  comp_t           out_w_o,
  input  logic [LenW-1:0] vec_length_o,
  input  logic            was_normalized_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  input  logic            pready,
  output int              fail_count,
  output int              pending
);

  typedef struct packed {
    comp_t           x, y, z, w;
    logic [LenW-1:0] len;
    logic            norm;
  } norm_result_t;

  norm_result_t    expected_q[$];
  logic [LenW-1:0] threshold;

  assign pending = expected_q.size();

  // floor of square root, bit by bit
  function automatic logic [LenW-1:0] root_floor(logic [SumW-1:0] s);
    logic [35:0] rem, res, bitv;
    rem = 36'(s);
    res = '0;
    bitv = 36'd1 << 34;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[LenW-1:0];
  endfunction

  function automatic comp_t scale_comp(comp_t c, logic [LenW-1:0] len);
    longint mag, q, r;
    mag = (c < 0) ? -longint'(c) : longint'(c);
    q = (mag * 4096 + longint'(len) / 2) / longint'(len);
    r = (c < 0) ? -q : q;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return comp_t'(r);
  endfunction

  function automatic norm_result_t predict_norm(comp_t x, comp_t y, comp_t z, comp_t w);
    norm_result_t    r;
    logic [SumW-1:0] s;
    s = SumW'(longint'(x) * x) + SumW'(longint'(y) * y)
      + SumW'(longint'(z) * z) + SumW'(longint'(w) * w);
    r.len  = root_floor(s);
    r.norm = r.len > threshold;
    r.x = r.norm ? scale_comp(x, r.len) : x;
    r.y = r.norm ? scale_comp(y, r.len) : y;
    r.z = r.norm ? scale_comp(z, r.len) : z;
    r.w = r.norm ? scale_comp(w, r.len) : w;
    return r;
  endfunction

  // track config, predict items, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    norm_result_t got, exp_r;
    if (!rst_ni) begin
      threshold <= MinLenReset;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && !paddr[2])
        threshold <= pwdata[LenW-1:0];
      if (start && !busy)
        expected_q.push_back(predict_norm(comp_x_i, comp_y_i, comp_z_i, comp_w_i));
      if (done_o) begin
        got = '{out_x_o, out_y_o, out_z_o, out_w_o, vec_length_o, was_normalized_o};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            $display({"%0t: mismatch x/y/z/w/len/norm expected %0d %0d %0d %0d %0d %0b",
                      " actual %0d %0d %0d %0d %0d %0b"},
                     $time, exp_r.x, exp_r.y, exp_r.z, exp_r.w, exp_r.len, exp_r.norm,
                     got.x, got.y, got.z, got.w, got.len, got.norm);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/vec4_normalize_test.sv =====
// Top of the vec4_normalize testbench: clock, reset, config writes and items.
// Depends on v4n_pkg, vec4_normalize and vec4_normalize_checker.
`timescale 1ns / 100ps
module vec4_normalize_test;
  import v4n_pkg::*;

  localparam int Latency = 34;
  localparam int CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy, done_o, was_normalized_o, pready;
  comp_t comp_x_i = '0, comp_y_i = '0, comp_z_i = '0, comp_w_i = '0;
  comp_t out_x_o, out_y_o, out_z_o, out_w_o;
  logic [LenW-1:0] vec_length_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  int fail_count, pending, cycles;

  vec4_normalize dut (.*);
  vec4_normalize_checker chk (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard limit on run length
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_threshold(logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // drive one item, with a random idle gap before it unless burst
  task automatic send_vec(comp_t x, comp_t y, comp_t z, comp_t w, bit burst);
    while (!burst && $urandom_range(99) < 18) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    comp_x_i <= x; comp_y_i <= y; comp_z_i <= z; comp_w_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic comp_t rand_comp(int mode);
    case (mode)
      0: return comp_t'($urandom);
      1: return comp_t'($urandom_range(8191) - 4096);
      2: return comp_t'($urandom_range(15) - 8);
      default: return $urandom_range(1) ? comp_t'(16'sh7fff) : comp_t'(16'sh8000);
    endcase
  endfunction

  initial begin
    logic [31:0] thresholds [6];
    int mode;
    thresholds = '{32'd0, 32'h1_FFFF, 32'd4096, 32'hFFFE_0010, 32'd200, 32'd1};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zero vector, tiny vectors, ties
    send_vec(0, 0, 0, 0, 1);
    send_vec(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1);
    send_vec(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1);
    send_vec(16'sh8000, 0, 0, 0, 1);
    send_vec(0, 16'sh7fff, 0, 0, 1);
    send_vec(1, 0, 0, 0, 1);
    send_vec(0, 0, 0, -1, 1);
    send_vec(1, 1, 1, 1, 1);
    send_vec(2, -1, 0, 0, 1);
    send_vec(3, 4, 0, 0, 1);
    send_vec(-3, 0, 4, 0, 1);
    send_vec(4096, 0, 0, 0, 1);
    send_vec(-4096, 4096, -4096, 4096, 1);
    send_vec(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 1);
    drain();
    write_threshold(0);
    send_vec(0, 0, 0, 0, 1);
    send_vec(1, 0, 0, 0, 1);
    send_vec(0, -1, 1, 0, 1);
    drain();
    write_threshold(32'h1_FFFF);
    send_vec(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1);
    send_vec(100, 200, 300, 400, 1);
    drain();

    // random phases over several thresholds
    for (int p = 0; p < 6; p++) begin
      write_threshold(thresholds[p]);
      for (int i = 0; i < 200; i++) begin
        mode = $urandom_range(9);
        mode = (mode < 5) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
        send_vec(rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode),
                 p == 2 && i > 40 && i < 140);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
